// ----- rtl/core/sfcc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, constants and the CRC-8 byte step for the sensor frame unit.
// ----------------------------------------------------------------------------
package sfcc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // byte positions within the six-byte read frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // conversion scale factors, both divided by 65535
    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

    localparam int TEMP_PROD_W = 31;
    localparam int HUM_PROD_W  = 30;

    // completed-frame event from the frame tracker
    typedef struct packed {
        logic                   done;
        logic                   temp_ok;
        logic                   hum_ok;
        logic [TEMP_PROD_W-1:0] temp_prod;
        logic [HUM_PROD_W-1:0]  hum_prod;
    } frame_evt_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/sfcc_frame.sv -----
// ----------------------------------------------------------------------------
// sfcc_frame
// Byte position tracking, running CRC checks and raw-word scaling products.
// ----------------------------------------------------------------------------
module sfcc_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_acc,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    output sfcc_pkg::frame_evt_t evt
);
    import sfcc_pkg::*;

    logic [2:0]             pos_reg, pos_next;
    logic [7:0]             crc_reg, crc_next;
    logic [7:0]             high_reg, high_next;
    logic                   first_ok_reg, first_ok_next;
    logic [TEMP_PROD_W-1:0] temp_prod_reg, temp_prod_next;
    logic [HUM_PROD_W-1:0]  hum_prod_reg, hum_prod_next;

    logic [2:0]  pos;
    logic [7:0]  crc_seed;
    logic [7:0]  crc_step;
    logic [15:0] word;

    always_comb
    begin
        pos = (frame_start || (pos_reg > POS_H_CRC)) ? POS_T_HI : pos_reg;
        // CRC restarts at the high byte of each word
        crc_seed = ((pos == POS_T_HI) || (pos == POS_H_HI)) ? CRC_INIT : crc_reg;
        crc_step = crc8_byte(crc_seed, data_byte);
        word     = {high_reg, data_byte};
    end

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        high_next      = high_reg;
        first_ok_next  = first_ok_reg;
        temp_prod_next = temp_prod_reg;
        hum_prod_next  = hum_prod_reg;
        evt            = '0;
        evt.temp_ok    = first_ok_reg;
        evt.hum_ok     = (crc_reg == data_byte);
        evt.temp_prod  = temp_prod_reg;
        evt.hum_prod   = hum_prod_reg;
        if (in_acc)
        begin
            case (pos)
                POS_T_HI, POS_H_HI:
                begin
                    crc_next  = crc_step;
                    high_next = data_byte;
                    pos_next  = pos + 3'd1;
                end
                POS_T_LO:
                begin
                    crc_next       = crc_step;
                    temp_prod_next = TEMP_PROD_W'(word) * TEMP_PROD_W'(TEMP_SCALE);
                    pos_next       = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    first_ok_next = (crc_reg == data_byte);
                    crc_next      = CRC_INIT;
                    pos_next      = POS_H_HI;
                end
                POS_H_LO:
                begin
                    crc_next      = crc_step;
                    hum_prod_next = HUM_PROD_W'(word) * HUM_PROD_W'(HUM_SCALE);
                    pos_next      = POS_H_CRC;
                end
                default:
                begin
                    evt.done = 1'b1;
                    crc_next = CRC_INIT;
                    pos_next = POS_T_HI;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            high_reg      <= '0;
            first_ok_reg  <= 1'b0;
            temp_prod_reg <= '0;
            hum_prod_reg  <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            first_ok_reg  <= first_ok_next;
            temp_prod_reg <= temp_prod_next;
            hum_prod_reg  <= hum_prod_next;
        end
    end

endmodule

// ----- rtl/core/sfcc_convert.sv -----
// ----------------------------------------------------------------------------
// sfcc_convert
// Divide-by-65535 of the scaled words, last-good hold and result register.
// ----------------------------------------------------------------------------
module sfcc_convert (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfcc_pkg::frame_evt_t evt,
    input  logic                 out_take,
    output logic                 out_valid,
    output logic [14:0]          temperature_centi,
    output logic [13:0]          humidity_centi,
    output logic                 temp_crc_ok,
    output logic                 hum_crc_ok,
    output logic                 values_updated
);
    import sfcc_pkg::*;

    logic        valid_reg, valid_next;
    logic [14:0] good_t_reg, good_t_next;
    logic [13:0] good_h_reg, good_h_next;
    logic [14:0] out_t_reg, out_t_next;
    logic [13:0] out_h_reg, out_h_next;
    logic [2:0]  flags_reg, flags_next;

    logic [14:0] tq0;
    logic [16:0] tr;
    logic [14:0] tq;
    logic [13:0] hq0;
    logic [16:0] hr;
    logic [13:0] hq;
    logic        upd;

    // p / 65535 = q0 + (((p mod 2^16) + q0) >= 65535), with q0 = p >> 16
    always_comb
    begin
        tq0 = evt.temp_prod[TEMP_PROD_W-1:16];
        tr  = {1'b0, evt.temp_prod[15:0]} + {2'b00, tq0};
        tq  = (tr >= {1'b0, FULL_SCALE}) ? tq0 + 15'd1 : tq0;
        hq0 = evt.hum_prod[HUM_PROD_W-1:16];
        hr  = {1'b0, evt.hum_prod[15:0]} + {3'b000, hq0};
        hq  = (hr >= {1'b0, FULL_SCALE}) ? hq0 + 14'd1 : hq0;
        upd = evt.temp_ok & evt.hum_ok;
    end

    always_comb
    begin
        good_t_next = good_t_reg;
        good_h_next = good_h_reg;
        out_t_next  = out_t_reg;
        out_h_next  = out_h_reg;
        flags_next  = flags_reg;
        valid_next  = valid_reg & ~out_take;
        if (evt.done)
        begin
            valid_next = 1'b1;
            flags_next = {upd, evt.hum_ok, evt.temp_ok};
            if (upd)
            begin
                good_t_next = tq - TEMP_OFFSET;
                good_h_next = hq;
                out_t_next  = tq - TEMP_OFFSET;
                out_h_next  = hq;
            end
            else
            begin
                out_t_next = good_t_reg;
                out_h_next = good_h_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            good_t_reg <= '0;
            good_h_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            good_t_reg <= good_t_next;
            good_h_reg <= good_h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_t_reg <= out_t_next;
        out_h_reg <= out_h_next;
        flags_reg <= flags_next;
    end

    assign out_valid         = valid_reg;
    assign temperature_centi = out_t_reg;
    assign humidity_centi    = out_h_reg;
    assign temp_crc_ok       = flags_reg[0];
    assign hum_crc_ok        = flags_reg[1];
    assign values_updated    = flags_reg[2];

endmodule

// ----- rtl/core/sensor_frame_crc_and_convert_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_crc_and_convert_unit
// Checked temperature/humidity frame decoder with unit conversion.
// ----------------------------------------------------------------------------
// Takes a six-byte sensor read frame one byte per transfer (temperature word,
// its CRC-8, humidity word, its CRC-8; CRC poly 0x31, init 0xFF) and after the
// sixth byte delivers one result: temperature in 0.01 degC, humidity in
// 0.01 %RH and the CRC flags. Values are replaced only when both CRCs match,
// otherwise the last good values repeat (zeros after reset). tuser high on a
// byte restarts the frame and drops any partial one. One byte is accepted
// every cycle while s_tready is high; the scaling multiply is done when a
// word's low byte arrives, so the result is registered on the same edge that
// takes the last CRC byte. s_tready only drops while a finished result sits
// unread in the output register.
// ----------------------------------------------------------------------------
module sensor_frame_crc_and_convert_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
    output logic [2:0]  m_tuser    // [0] temp_crc_ok, [1] hum_crc_ok, [2] values_updated
);
    import sfcc_pkg::*;

    frame_evt_t  evt;
    logic        in_acc;
    logic        out_take;
    logic [14:0] temperature_centi;
    logic [13:0] humidity_centi;
    logic        temp_crc_ok;
    logic        hum_crc_ok;
    logic        values_updated;

    assign s_tready = !m_tvalid || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    sfcc_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_acc      (in_acc),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .evt         (evt)
    );

    sfcc_convert u_convert (
        .clk               (clk),
        .rst_n             (rst_n),
        .evt               (evt),
        .out_take          (out_take),
        .out_valid         (m_tvalid),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .temp_crc_ok       (temp_crc_ok),
        .hum_crc_ok        (hum_crc_ok),
        .values_updated    (values_updated)
    );

    assign m_tdata = {3'b000, humidity_centi, temperature_centi};
    assign m_tuser = {values_updated, hum_crc_ok, temp_crc_ok};

    a_upd_needs_both_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser[2] || (m_tuser[0] && m_tuser[1])))
        else $error("values_updated without both CRCs passing");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[28:15] <= 14'd10000))
        else $error("humidity out of range");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(m_tdata[14:0]) >= -15'sd4500)
                      && ($signed(m_tdata[14:0]) <= 15'sd13000)))
        else $error("temperature out of range");

endmodule

// ----- bench/sensor_frame_crc_and_convert_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_crc_and_convert_unit_tb
// Self-checking bench for the CRC-checked temperature/humidity frame decoder.
// ----------------------------------------------------------------------------
// Feeds six-byte sensor frames (plus partial and misaligned runs) byte by byte
// through the input stream, predicts every reading from its own copy of the
// frame tracker and compares each output transfer against the oldest
// predicted reading. Sender bursts and receiver stalls are random, with one
// long receiver hold-off that backs the stream up into the input side.
// ----------------------------------------------------------------------------
module sensor_frame_crc_and_convert_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sfcc_pkg::*;

    localparam int TARGET_BYTES = 800;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } frame_byte_t;

    typedef struct packed {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic               t_ok;
        logic               h_ok;
        logic               upd;
    } reading_t;

    // ------------------------------------------------------------------------
    // frame tracker model plus reading checker
    // ------------------------------------------------------------------------
    class reading_scoreboard;
        logic [2:0]         position  = POS_T_HI;
        logic [7:0]         crc_acc   = CRC_INIT;
        logic [7:0]         high_byte = '0;
        logic [15:0]        t_raw     = '0;
        logic               t_ok      = 1'b0;
        logic [15:0]        h_raw     = '0;
        logic signed [14:0] good_temp = '0;
        logic [13:0]        good_hum  = '0;

        reading_t expected_readings[$];
        int errors;
        int bytes_noted;
        int readings_checked;
        int updates;
        int temp_crc_fails;
        int hum_crc_fails;

        // bit-serial CRC-8, MSB first
        static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c;
            for (int k = 7; k >= 0; k--)
            begin
                if (r[7] ^ b[k])
                    r = {r[6:0], 1'b0} ^ CRC_POLY;
                else
                    r = {r[6:0], 1'b0};
            end
            return r;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            logic [2:0]  slot;
            logic        h_ok;
            int unsigned scaled;
            int          t_val;
            reading_t    r;
            bytes_noted++;
            slot = position;
            if (start || slot > POS_H_CRC)
                slot = POS_T_HI;
            case (slot)
                POS_T_HI, POS_H_HI:
                begin
                    crc_acc   = crc_step(CRC_INIT, b);
                    high_byte = b;
                    position  = slot + 3'd1;
                end
                POS_T_LO:
                begin
                    crc_acc  = crc_step(crc_acc, b);
                    t_raw    = {high_byte, b};
                    position = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    t_ok     = (crc_acc == b);
                    crc_acc  = CRC_INIT;
                    position = POS_H_HI;
                end
                POS_H_LO:
                begin
                    crc_acc  = crc_step(crc_acc, b);
                    h_raw    = {high_byte, b};
                    position = POS_H_CRC;
                end
                default:
                begin
                    h_ok = (crc_acc == b);
                    if (t_ok && h_ok)
                    begin
                        scaled    = 32'(t_raw) * 32'd17500;
                        t_val     = int'(scaled / 32'd65535) - 4500;
                        good_temp = t_val[14:0];
                        scaled    = 32'(h_raw) * 32'd10000;
                        good_hum  = 14'(scaled / 32'd65535);
                        updates++;
                    end
                    temp_crc_fails += int'(!t_ok);
                    hum_crc_fails  += int'(!h_ok);
                    r.temp = good_temp;
                    r.hum  = good_hum;
                    r.t_ok = t_ok;
                    r.h_ok = h_ok;
                    r.upd  = t_ok && h_ok;
                    expected_readings.push_back(r);
                    crc_acc  = CRC_INIT;
                    position = POS_T_HI;
                end
            endcase
        endfunction

        function void check_reading(logic [31:0] tdata, logic [2:0] tuser);
            reading_t got;
            reading_t want;
            got.temp = tdata[14:0];
            got.hum  = tdata[28:15];
            got.t_ok = tuser[0];
            got.h_ok = tuser[1];
            got.upd  = tuser[2];
            readings_checked++;
            if (expected_readings.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected reading temp=%0d hum=%0d flags=%b",
                             got.temp, got.hum, tuser);
                return;
            end
            want = expected_readings.pop_front();
            if (got != want || tdata[31:29] != 3'b000)
            begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: reading %0d: exp temp=%0d hum=%0d t_ok=%b h_ok=%b ",
                              "upd=%b, got temp=%0d hum=%0d t_ok=%b h_ok=%b upd=%b pad=%b"},
                             readings_checked, want.temp, want.hum, want.t_ok, want.h_ok,
                             want.upd, got.temp, got.hum, got.t_ok, got.h_ok, got.upd,
                             tdata[31:29]);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    reading_scoreboard sb = new;
    frame_byte_t       stim_q[$];
    bit                held_off;
    int                cycles;

    sensor_frame_crc_and_convert_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readings outstanding",
                     cycles, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // input transfers are noted before output transfers of the same edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tuser);
        if (rst_n && m_tvalid && m_tready)
            sb.check_reading(m_tdata, m_tuser);
    end

    // receiver: random stall pattern in random-length phases, one long hold-off
    initial
    begin
        int phase_left;
        int mode;
        int tick;
        phase_left = 0;
        mode       = 0;
        tick       = 0;
        forever
        begin
            @(posedge clk);
            if (!held_off && sb.readings_checked >= 30)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (phase_left == 0)
            begin
                mode       = $urandom_range(0, 3);
                phase_left = $urandom_range(16, 80);
            end
            phase_left--;
            tick++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 4) == 0);
                default: m_tready <= ((tick % 7) < 3);
            endcase
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic st);
        frame_byte_t fb;
        fb.data  = d;
        fb.start = st;
        stim_q.push_back(fb);
    endtask

    task automatic push_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input bit bad_t, input bit bad_h, input logic st);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = reading_scoreboard::crc_step(
                    reading_scoreboard::crc_step(CRC_INIT, t_word[15:8]), t_word[7:0]);
        h_crc = reading_scoreboard::crc_step(
                    reading_scoreboard::crc_step(CRC_INIT, h_word[15:8]), h_word[7:0]);
        if (bad_t)
            t_crc ^= 8'($urandom_range(1, 255));
        if (bad_h)
            h_crc ^= 8'($urandom_range(1, 255));
        push_byte(t_word[15:8], st);
        push_byte(t_word[7:0], 1'b0);
        push_byte(t_crc, 1'b0);
        push_byte(h_word[15:8], 1'b0);
        push_byte(h_word[7:0], 1'b0);
        push_byte(h_crc, 1'b0);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_byte(input frame_byte_t fb);
        s_tvalid <= 1'b1;
        s_tdata  <= fb.data;
        s_tuser  <= fb.start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int  idx;
        int  burst;
        int  gap;
        int  n;
        bit  after_noise;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b0;
        rst_n    = 1'b0;
        cycles   = 0;
        held_off = 1'b0;

        // directed: bad temperature CRC before any good frame (reset zeros out)
        push_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1);
        // back-to-back, no start flag, both good, extremes
        push_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        // partial frame cut off by a start flag mid-frame
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b0);
        // good temperature, bad humidity: old values repeat
        push_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1);
        // start flag at position zero, both good
        push_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1);

        // random: mostly well-formed frames, some broken runs
        after_noise = 1'b0;
        while (stim_q.size() < TARGET_BYTES)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom()), (i == 0) ? 1'($urandom_range(0, 1))
                                                       : ($urandom_range(0, 9) == 0));
                after_noise = 1'b1;
            end
            else
            begin
                push_frame(pick_word(), pick_word(),
                           $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15,
                           after_noise ? ($urandom_range(0, 4) != 0)
                                       : ($urandom_range(0, 9) < 6));
                after_noise = 1'b0;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        idx = 0;
        while (idx < stim_q.size())
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 24);
            for (int i = 0; i < burst && idx < stim_q.size(); i++)
            begin
                send_byte(stim_q[idx]);
                idx++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d byte transfers and %0d readings: %0d updates, %0d temp CRC fails,",
                 sb.bytes_noted, sb.readings_checked, sb.updates, sb.temp_crc_fails);
        $display("%0d humidity CRC fails, long receiver hold-off %0s; %0d mismatches",
                 sb.hum_crc_fails, held_off ? "done" : "not reached", sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/sfcc_pkg.sv
rtl/core/sfcc_frame.sv
rtl/core/sfcc_convert.sv
rtl/core/sensor_frame_crc_and_convert_unit.sv
bench/sensor_frame_crc_and_convert_unit_tb.sv
